// ----- hdl/keyword_occurrence_counter_defines.svh -----
// Assertion macros for the keyword occurrence counter's word tracker.
`ifndef KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH
`define KEYWORD_OCCURRENCE_COUNTER_DEFINES_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define KWC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define KWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KWC_ASSERT(label, prop, msg)
`define KWC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- hdl/kwc_pkg.sv -----
// Shared constants, keyword table, types and helpers for the keyword occurrence counter.
package kwc_pkg;

    localparam int NUM_KEYS     = 9;
    localparam int MAX_WORD_LEN = 100;
    localparam int COUNT_WIDTH  = 16;
    localparam int LEN_W        = $clog2(MAX_WORD_LEN + 1);
    localparam int KEY_BYTES    = 8;
    localparam int KEY_POS_W    = $clog2(KEY_BYTES);
    localparam int KEY_LEN_W    = 4;
    localparam int INDEX_W      = 4;

    typedef logic [LEN_W-1:0]       len_t;
    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [KEY_LEN_W-1:0]   key_len_t;
    typedef logic [INDEX_W-1:0]     index_t;

    localparam logic [7:0] KEY_TEXT [NUM_KEYS][KEY_BYTES] = '{
        '{"a", "u", "t", "o", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
        '{"c", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"c", "o", "n", "t", "i", "n", "u", "e"},
        '{"u", "n", "s", "i", "g", "n", "e", "d"},
        '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"v", "o", "l", "a", "t", "i", "l", "e"},
        '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00}
    };

    localparam key_len_t KEY_LEN [NUM_KEYS] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd8, 4'd8, 4'd4, 4'd8, 4'd5
    };

    // Word tracker to cell broadcast, valid for one cycle.
    typedef struct packed {
        logic       take;      // acceptable byte is consumed
        logic       restart;   // byte starts a new word
        logic [7:0] ch;
        len_t       pos;       // position of ch within the word
        logic       close;     // pending word ends this cycle
        len_t       close_len; // word length at close
        logic       shift;     // report advances one entry
    } ctrl_t;

    function automatic logic is_word_char(input logic [7:0] c);
        logic lower, upper, digit, punct;
        lower = (c >= "a") && (c <= "z");
        upper = (c >= "A") && (c <= "Z");
        digit = (c >= "0") && (c <= "9");
        punct = (c == "_") || (c == 8'h22) || (c == "#") || (c == "/");
        return lower || upper || digit || punct;
    endfunction

endpackage

// ----- hdl/kwc_cell.sv -----
// One keyword cell: its candidate match bit and its saturating occurrence counter.
module kwc_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  kwc_pkg::ctrl_t     ctrl,
    input  logic [7:0]         key_byte,
    input  kwc_pkg::key_len_t  key_len,
    input  kwc_pkg::count_t    count_in,
    output kwc_pkg::count_t    count
);

    logic            cand_reg;
    logic            cand_next;
    kwc_pkg::count_t count_reg;
    kwc_pkg::count_t count_next;
    logic            cand_eff;
    logic            cand_new;
    logic            hit;

    always_comb
    begin
        cand_eff = ctrl.restart ? 1'b1 : cand_reg;
        if (ctrl.take)
        begin
            cand_new = cand_eff && (ctrl.pos < kwc_pkg::LEN_W'(key_len))
                       && (key_byte == ctrl.ch);
        end
        else
        begin
            cand_new = cand_eff;
        end
        hit = ctrl.close && cand_new && (ctrl.close_len == kwc_pkg::LEN_W'(key_len));
    end

    always_comb
    begin
        cand_next = ctrl.close ? 1'b1 : cand_new;
        if (ctrl.shift)
        begin
            count_next = count_in;
        end
        else if (hit && (count_reg != '1))
        begin
            count_next = count_reg + kwc_pkg::COUNT_WIDTH'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg  <= 1'b1;
            count_reg <= '0;
        end
        else
        begin
            cand_reg  <= cand_next;
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ----- hdl/kwc_track.sv -----
// Word boundary tracker and report sequencer that drives the keyword cells.
`include "keyword_occurrence_counter_defines.svh"

module kwc_track
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        char_code,
    input  logic              end_of_input,
    output logic              m_tvalid,
    input  logic              m_tready,
    output kwc_pkg::index_t   keyword_index,
    output logic              last_entry,
    output kwc_pkg::ctrl_t    ctrl
);

    logic            in_word_reg;
    logic            in_word_next;
    kwc_pkg::len_t   len_reg;
    kwc_pkg::len_t   len_next;
    logic            report_reg;
    logic            report_next;
    kwc_pkg::index_t index_reg;
    kwc_pkg::index_t index_next;

    logic            acc;
    logic            byte_acc;
    logic            is_end;
    logic            ok;
    logic            out_acc;
    kwc_pkg::len_t   new_len;
    logic            max_hit;

    assign s_tready   = !report_reg;
    assign acc        = s_tvalid && s_tready;
    assign is_end     = acc && end_of_input;
    assign byte_acc   = acc && !end_of_input;
    assign ok         = kwc_pkg::is_word_char(char_code);
    assign m_tvalid   = report_reg;
    assign out_acc    = m_tvalid && m_tready;
    assign last_entry = (index_reg == kwc_pkg::INDEX_W'(kwc_pkg::NUM_KEYS - 1));
    assign keyword_index = index_reg;

    always_comb
    begin
        ctrl.take    = byte_acc && ok;
        ctrl.restart = !in_word_reg;
        ctrl.ch      = char_code;
        ctrl.pos     = in_word_reg ? len_reg : '0;
        new_len      = ctrl.pos + kwc_pkg::LEN_W'(1);
        max_hit      = (new_len >= kwc_pkg::LEN_W'(kwc_pkg::MAX_WORD_LEN));
        // A word closes on a separator, on end of input, or when it reaches the cap.
        ctrl.close   = (ctrl.take && max_hit)
                       || (in_word_reg && ((byte_acc && !ok) || is_end));
        ctrl.close_len = ctrl.take ? new_len : len_reg;
        ctrl.shift   = out_acc;
    end

    always_comb
    begin
        if (ctrl.take)
        begin
            in_word_next = !max_hit;
            len_next     = max_hit ? '0 : new_len;
        end
        else if (acc)
        begin
            in_word_next = 1'b0;
            len_next     = '0;
        end
        else
        begin
            in_word_next = in_word_reg;
            len_next     = len_reg;
        end
    end

    always_comb
    begin
        report_next = report_reg;
        index_next  = index_reg;
        if (is_end)
        begin
            report_next = 1'b1;
            index_next  = '0;
        end
        else if (out_acc)
        begin
            if (last_entry)
            begin
                report_next = 1'b0;
            end
            index_next = index_reg + kwc_pkg::INDEX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_word_reg <= 1'b0;
            len_reg     <= '0;
            report_reg  <= 1'b0;
            index_reg   <= '0;
        end
        else
        begin
            in_word_reg <= in_word_next;
            len_reg     <= len_next;
            report_reg  <= report_next;
            index_reg   <= index_next;
        end
    end

    `KWC_ASSERT(a_no_overlap, !(s_tready && m_tvalid), "input open during report")
    `KWC_ASSERT_NEXT(a_report_start, is_end, m_tvalid && (index_reg == '0), "report did not start")
    `KWC_ASSERT_NEXT(a_report_end, out_acc && last_entry, s_tready && !m_tvalid, "report did not end")
    `KWC_ASSERT(a_len_cap, len_reg < kwc_pkg::LEN_W'(kwc_pkg::MAX_WORD_LEN), "word length over cap")

endmodule

// ----- hdl/keyword_occurrence_counter.sv -----
// Top level of the keyword occurrence counter: word tracker and a row of keyword cells.
//
//  channel   direction  tdata (low bit up)                        tuser / tlast
//  s_*       in         char_code[7:0]                            tuser = end_of_input
//  m_*       out        keyword_index[3:0], keyword_count[19:4]   tlast = last_entry
//
// Outside a report a byte is taken every cycle and updates each cell's match bit and counter.
// An end_of_input item closes the pending word and starts a report of one item per keyword,
// read from the first cell while the counters shift toward it and fill with zeros behind.
// s_tready is low for the whole report, which m_tready can stall.
// Reset clears the counters, the word state and the report sequencer at once.
module keyword_occurrence_counter
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // keyword_index[3:0], keyword_count[19:4], zero pad
    output logic        m_tlast
);

    kwc_pkg::ctrl_t  ctrl;
    kwc_pkg::index_t keyword_index;
    kwc_pkg::count_t counts [kwc_pkg::NUM_KEYS + 1];

    kwc_track u_track
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .char_code     (s_tdata),
        .end_of_input  (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .keyword_index (keyword_index),
        .last_entry    (m_tlast),
        .ctrl          (ctrl)
    );

    // Zeros enter behind the last cell so the counters are clear after the report.
    assign counts[kwc_pkg::NUM_KEYS] = '0;

    for (genvar k = 0; k < kwc_pkg::NUM_KEYS; k++)
    begin : g_cell
        kwc_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .key_byte (kwc_pkg::KEY_TEXT[k][ctrl.pos[kwc_pkg::KEY_POS_W-1:0]]),
            .key_len  (kwc_pkg::KEY_LEN[k]),
            .count_in (counts[k + 1]),
            .count    (counts[k])
        );
    end

    assign m_tdata = {(24 - kwc_pkg::INDEX_W - kwc_pkg::COUNT_WIDTH)'(0), counts[0], keyword_index};

endmodule
